// File: design/lppd_pkg.sv
// Shared types and constants for the length-prefixed packet deframer.
package lppd_pkg;

	// First length byte that announces a 16-bit extension; the next code announces 32 bits.
	localparam logic [7:0] PREFIX_16 = 8'd254;

	// Number of extension bytes that follow each escape code.
	localparam logic [2:0] EXT16_BYTES = 3'd2;
	localparam logic [2:0] EXT32_BYTES = 3'd4;

	typedef enum logic [2:0] {
		PH_TYPE    = 3'd0,
		PH_LEN     = 3'd1,
		PH_EXT16   = 3'd2,
		PH_EXT32   = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// Input command codes.
	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// One result beat.
	typedef struct packed {
		logic [7:0]  packet_type;
		logic [7:0]  payload_byte;
		logic [31:0] packet_length;
		logic        last_of_packet;
		logic        empty_packet;
	} result_t;

endpackage

// File: design/length_prefixed_packet_deframer_top.sv
// Top level of the length-prefixed packet deframer: input register, parser and result register.
//
// The deframer takes one stream byte or one clear command per beat and splits the stream into
// packets made of a type byte, a length prefix and the payload. A first length byte below 254
// is the length itself; 254 announces a 16-bit little-endian length and 255 a 32-bit one. Each
// payload byte leaves as one result beat tagged with the packet type, the decoded length and a
// last flag, while a zero-length packet gives a single beat marked empty on the byte that
// completes its length. Header bytes and clear commands give no result; clear drops any partial
// packet. The block takes one beat per clock cycle, sustained, while the output does not stall;
// an accepted input beat passes through the input register and then the result register on
// its way to the output. The parser's state advances once per input beat, so a stall on
// the output holds only the beat that needs the result register, and the input register keeps
// taking beats as long as the item in front of it can move on.
module length_prefixed_packet_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  packet_type,
	output logic [7:0]  payload_byte,
	output logic [31:0] packet_length,
	output logic        last_of_packet,
	output logic        empty_packet
);
	import lppd_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] data_byte_s1;

	logic    emit;
	logic    out_free;
	logic    advance;
	result_t parser_res;
	result_t out_res;

	// The beat in the input register moves on when it needs no result slot or the slot is free.
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1   <= command;
			data_byte_s1 <= data_byte;
		end
	end

	lppd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.command   (command_s1),
		.data_byte (data_byte_s1),
		.emit      (emit),
		.res       (parser_res)
	);

	lppd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.load_res  (parser_res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (out_res)
	);

	assign packet_type    = out_res.packet_type;
	assign payload_byte   = out_res.payload_byte;
	assign packet_length  = out_res.packet_length;
	assign last_of_packet = out_res.last_of_packet;
	assign empty_packet   = out_res.empty_packet;

endmodule

// File: design/lppd_parser.sv
// Framing state machine: tracks the header phase, decodes the length and counts payload bytes.
module lppd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              command,
	input  logic [7:0]        data_byte,
	output logic              emit,
	output lppd_pkg::result_t res
);
	import lppd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [31:0] len_q, len_d;
	logic [2:0]  prefix_left_q, prefix_left_d;
	logic [31:0] payload_left_q, payload_left_d;

	logic [31:0] len_shifted;
	logic [31:0] len_final;
	logic [2:0]  prefix_dec;
	logic [31:0] payload_dec;

	// Little-endian extension bytes enter at the top of the accumulator.
	assign len_shifted = {data_byte, len_q[31:8]};
	assign len_final   = (phase_q == PH_EXT16) ? {16'd0, len_shifted[31:16]} : len_shifted;
	assign prefix_dec  = prefix_left_q - 3'd1;
	assign payload_dec = payload_left_q - 32'd1;

	// Next state.
	always_comb begin
		phase_d        = phase_q;
		type_d         = type_q;
		len_d          = len_q;
		prefix_left_d  = prefix_left_q;
		payload_left_d = payload_left_q;
		if (command == CMD_CLEAR) begin
			phase_d        = PH_TYPE;
			type_d         = 8'd0;
			len_d          = 32'd0;
			prefix_left_d  = 3'd0;
			payload_left_d = 32'd0;
		end else begin
			unique case (phase_q)
				PH_LEN: begin
					if (data_byte < PREFIX_16) begin
						len_d          = {24'd0, data_byte};
						prefix_left_d  = 3'd0;
						payload_left_d = {24'd0, data_byte};
						phase_d        = (data_byte == 8'd0) ? PH_TYPE : PH_PAYLOAD;
					end else if (data_byte == PREFIX_16) begin
						len_d         = 32'd0;
						prefix_left_d = EXT16_BYTES;
						phase_d       = PH_EXT16;
					end else begin
						len_d         = 32'd0;
						prefix_left_d = EXT32_BYTES;
						phase_d       = PH_EXT32;
					end
				end
				PH_EXT16, PH_EXT32: begin
					prefix_left_d = prefix_dec;
					if (prefix_dec != 3'd0) begin
						len_d = len_shifted;
					end else begin
						len_d          = len_final;
						payload_left_d = len_final;
						phase_d        = (len_final == 32'd0) ? PH_TYPE : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					payload_left_d = payload_dec;
					if (payload_dec == 32'd0) begin
						phase_d = PH_TYPE;
					end
				end
				default: begin
					type_d         = data_byte;
					len_d          = 32'd0;
					prefix_left_d  = 3'd0;
					payload_left_d = 32'd0;
					phase_d        = PH_LEN;
				end
			endcase
		end
	end

	// Result for the item now presented.
	always_comb begin
		emit               = 1'b0;
		res.packet_type    = type_q;
		res.payload_byte   = 8'd0;
		res.packet_length  = 32'd0;
		res.last_of_packet = 1'b1;
		res.empty_packet   = 1'b1;
		if (command == CMD_DATA) begin
			unique case (phase_q)
				PH_LEN: begin
					emit = (data_byte == 8'd0);
				end
				PH_EXT16, PH_EXT32: begin
					emit = (prefix_dec == 3'd0) && (len_final == 32'd0);
				end
				PH_PAYLOAD: begin
					emit               = 1'b1;
					res.payload_byte   = data_byte;
					res.packet_length  = len_q;
					res.last_of_packet = (payload_dec == 32'd0);
					res.empty_packet   = 1'b0;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_TYPE;
			type_q         <= 8'd0;
			len_q          <= 32'd0;
			prefix_left_q  <= 3'd0;
			payload_left_q <= 32'd0;
		end else if (step) begin
			phase_q        <= phase_d;
			type_q         <= type_d;
			len_q          <= len_d;
			prefix_left_q  <= prefix_left_d;
			payload_left_q <= payload_left_d;
		end
	end

endmodule

// File: design/lppd_out_reg.sv
// Result register that holds one beat until the downstream side takes it.
module lppd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lppd_pkg::result_t load_res,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output lppd_pkg::result_t res
);
	import lppd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

endmodule

// File: sim/tb.sv
// Self-checking testbench for the length-prefixed packet deframer.
import lppd_pkg::*;

class deframe_scoreboard;
	// Mirror of the parser state, advanced once per accepted input beat.
	phase_t      phase;
	logic [7:0]  held_type;
	logic [31:0] length_acc;
	logic [2:0]  prefix_left;
	logic [31:0] payload_left;

	result_t beats_due[$];
	int errors;
	int results_seen;
	int packets_closed;
	int empties;
	int clears;

	function new();
		reset_state();
		errors = 0;
		results_seen = 0;
		packets_closed = 0;
		empties = 0;
		clears = 0;
	endfunction

	function void reset_state();
		phase = PH_TYPE;
		held_type = '0;
		length_acc = '0;
		prefix_left = '0;
		payload_left = '0;
	endfunction

	// The length is complete: either the packet is empty and closes at once, or the payload starts.
	function void open_payload();
		result_t r;
		if (length_acc == 0) begin
			r.packet_type = held_type;
			r.payload_byte = '0;
			r.packet_length = '0;
			r.last_of_packet = 1'b1;
			r.empty_packet = 1'b1;
			beats_due.push_back(r);
			payload_left = '0;
			phase = PH_TYPE;
		end else begin
			payload_left = length_acc;
			phase = PH_PAYLOAD;
		end
	endfunction

	function void note_stream_beat(logic cmd, logic [7:0] b);
		result_t r;
		if (cmd == CMD_CLEAR) begin
			clears++;
			reset_state();
			return;
		end
		case (phase)
			PH_LEN: begin
				if (b < PREFIX_16) begin
					length_acc = {24'd0, b};
					prefix_left = '0;
					open_payload();
				end else begin
					length_acc = '0;
					if (b == PREFIX_16) begin
						phase = PH_EXT16;
						prefix_left = EXT16_BYTES;
					end else begin
						phase = PH_EXT32;
						prefix_left = EXT32_BYTES;
					end
				end
			end
			PH_EXT16, PH_EXT32: begin
				// Little-endian: each new byte enters at the top.
				length_acc = {b, length_acc[31:8]};
				prefix_left = prefix_left - 3'd1;
				if (prefix_left == 0) begin
					if (phase == PH_EXT16)
						length_acc = length_acc >> 16;
					open_payload();
				end
			end
			PH_PAYLOAD: begin
				payload_left = payload_left - 1;
				r.packet_type = held_type;
				r.payload_byte = b;
				r.packet_length = length_acc;
				r.last_of_packet = (payload_left == 0);
				r.empty_packet = 1'b0;
				beats_due.push_back(r);
				if (payload_left == 0)
					phase = PH_TYPE;
			end
			default: begin
				held_type = b;
				length_acc = '0;
				prefix_left = '0;
				payload_left = '0;
				phase = PH_LEN;
			end
		endcase
	endfunction

	function void match_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_payload_beat(result_t got);
		result_t want;
		if (beats_due.size() == 0) begin
			$error("result beat with nothing expected: type 0x%0h byte 0x%0h",
				got.packet_type, got.payload_byte);
			errors++;
			return;
		end
		want = beats_due.pop_front();
		results_seen++;
		if (want.last_of_packet)
			packets_closed++;
		if (want.empty_packet)
			empties++;
		match_field("packet_type", want.packet_type, got.packet_type);
		match_field("payload_byte", want.payload_byte, got.payload_byte);
		match_field("packet_length", want.packet_length, got.packet_length);
		match_field("last_of_packet", want.last_of_packet, got.last_of_packet);
		match_field("empty_packet", want.empty_packet, got.empty_packet);
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The escape code right above the 16-bit one announces a 32-bit length.
	localparam logic [7:0] PREFIX_32 = PREFIX_16 + 8'd1;

	// How a random packet writes its length on the wire.
	typedef enum {LEN_DIRECT, LEN_EXT16, LEN_EXT32} length_form_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  packet_type;
	logic [7:0]  payload_byte;
	logic [31:0] packet_length;
	logic        last_of_packet;
	logic        empty_packet;

	deframe_scoreboard sb;

	// Percent chance, per cycle, that the sender holds back or the receiver stalls.
	int send_idle_pct;
	int recv_stall_pct;
	int beats_in;

	length_prefixed_packet_deframer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packet_type   (packet_type),
		.payload_byte  (payload_byte),
		.packet_length (packet_length),
		.last_of_packet(last_of_packet),
		.empty_packet  (empty_packet)
	);

	always #1 clk = ~clk;

	// The receiver decides at each falling edge whether it takes a result at the next rising edge.
	always @(negedge clk) begin
		out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Every result beat the block hands over is checked against the oldest expectation. Results
	// cross the input and result registers, so the input noted at this same edge never matters here.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_payload_beat('{packet_type, payload_byte, packet_length,
				last_of_packet, empty_packet});
	end

	// Presents one beat on the input side and returns at the edge that accepts it. Valid stays
	// high from one beat to the next unless the sender decides to go idle for a while.
	task automatic send_beat(input logic cmd, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		command = cmd;
		data_byte = b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_stream_beat(cmd, b);
		beats_in++;
	endtask

	// Holds the input idle until every expected result has come out, then lets the pipeline
	// settle. A result still missing after the bound counts as a failure.
	task automatic wait_for_drain();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.beats_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.beats_due.size() != 0) begin
			$error("%0d result beats never arrived", sb.beats_due.size());
			sb.errors++;
		end
		repeat (6) @(posedge clk);
	endtask

	// One packet with random type, length and payload. Most lengths are short so that packets
	// complete; lengths past the direct range use an extension and are cut off by a clear after
	// a few payload bytes. A small share of packets is broken off early at a random point.
	task automatic send_random_packet();
		logic [7:0]   frame[$];
		logic [31:0]  len;
		length_form_t form;
		int           sel;
		int           body;
		int           stop;
		bit           cut;

		sel = $urandom_range(0, 99);
		if (sel < 2)
			len = $urandom_range(13, 253);
		else if (sel < 80)
			len = $urandom_range(0, 12);
		else if (sel < 90)
			len = $urandom_range(0, 16'hFFFF);
		else
			len = $urandom;

		if (len > 32'h0000_FFFF)
			form = LEN_EXT32;
		else if (len > 253)
			form = $urandom_range(0, 1) ? LEN_EXT16 : LEN_EXT32;
		else begin
			sel = $urandom_range(0, 9);
			form = (sel < 7) ? LEN_DIRECT : (sel < 9) ? LEN_EXT16 : LEN_EXT32;
		end

		frame.push_back(8'($urandom));
		case (form)
			LEN_DIRECT: frame.push_back(len[7:0]);
			LEN_EXT16: begin
				frame.push_back(PREFIX_16);
				frame.push_back(len[7:0]);
				frame.push_back(len[15:8]);
			end
			default: begin
				frame.push_back(PREFIX_32);
				frame.push_back(len[7:0]);
				frame.push_back(len[15:8]);
				frame.push_back(len[23:16]);
				frame.push_back(len[31:24]);
			end
		endcase

		cut = (len > 253);
		body = cut ? $urandom_range(0, 5) : int'(len);
		repeat (body)
			frame.push_back(8'($urandom));

		if ($urandom_range(0, 99) < 6) begin
			stop = $urandom_range(0, frame.size() - 2);
			frame = frame[0:stop];
			cut = 1'b1;
		end

		foreach (frame[i])
			send_beat(CMD_DATA, frame[i]);
		if (cut)
			send_beat(CMD_CLEAR, 8'($urandom));
		// Now and then a stray clear lands while the parser waits for a type byte.
		if ($urandom_range(0, 99) < 3)
			send_beat(CMD_CLEAR, 8'($urandom));
	endtask

	// Watchdog: far beyond the slowest correct run of roughly 600 beats with random gaps.
	initial begin
		#500000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int target;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_DATA;
		data_byte = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		beats_in = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. A clear right out of reset, while a type byte is awaited.
		send_beat(CMD_CLEAR, 8'hFF);
		// Zero-length packet in the direct form: one empty result on the length byte.
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'h00);
		// The largest direct length, with the top type code, dropped after one payload byte.
		send_beat(CMD_DATA, 8'hFF);
		send_beat(CMD_DATA, 8'd253);
		send_beat(CMD_DATA, 8'hA5);
		send_beat(CMD_CLEAR, 8'h00);
		// A 16-bit extension giving a one-byte packet.
		send_beat(CMD_DATA, 8'hA5);
		send_beat(CMD_DATA, PREFIX_16);
		send_beat(CMD_DATA, 8'h01);
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'hFF);
		// Empty packets whose length comes through the 16-bit and 32-bit extensions.
		send_beat(CMD_DATA, 8'h3C);
		send_beat(CMD_DATA, PREFIX_16);
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'h5A);
		send_beat(CMD_DATA, PREFIX_32);
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'h00);
		// The largest 32-bit length, one payload byte and then a clear.
		send_beat(CMD_DATA, 8'h81);
		send_beat(CMD_DATA, PREFIX_32);
		send_beat(CMD_DATA, 8'hFF);
		send_beat(CMD_DATA, 8'hFF);
		send_beat(CMD_DATA, 8'hFF);
		send_beat(CMD_DATA, 8'hFF);
		send_beat(CMD_DATA, 8'h7E);
		send_beat(CMD_CLEAR, 8'h5A);
		wait_for_drain();

		// Random part in four idling phases: none, a lazy sender, a stalling receiver, both.
		// Between phases the sender pauses until every expected result has arrived.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			target = beats_in + 125;
			while (beats_in < target)
				send_random_packet();
			wait_for_drain();
		end

		$display("Run covered %0d input beats including %0d clears.", beats_in, sb.clears);
		$display("Checked %0d result beats closing %0d packets, %0d of them empty.",
			sb.results_seen, sb.packets_closed, sb.empties);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
